[sv/csl_pkg.sv]
// Shared types, character codes and keyword table for the character stream lexer.
// Used by every module of the lexer; depends on nothing.
package csl_pkg;

  // Token class codes
  localparam logic [2:0] CLS_OPERATOR = 3'd0;
  localparam logic [2:0] CLS_IDENT    = 3'd1;
  localparam logic [2:0] CLS_SPECIAL  = 3'd2;
  localparam logic [2:0] CLS_KEYWORD  = 3'd3;
  localparam logic [2:0] CLS_NUMBER   = 3'd4;

  // Character codes with a role of their own
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_QUOTE  = 8'h27;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_PCT    = 8'h25;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  localparam int TEXT_BYTES = 8;

  // Keywords, first character in the low byte, unused bytes zero
  localparam int NUM_KW = 9;
  localparam logic [63:0] KW_TEXT [NUM_KW] = '{
    64'h0000_0000_0072_6F66,  // for
    64'h0000_0000_0074_6E69,  // int
    64'h0000_0000_0000_6669,  // if
    64'h0000_0000_6573_6C65,  // else
    64'h0000_0074_736E_6F63,  // const
    64'h0000_656C_6275_6F64,  // double
    64'h0000_0000_7261_6863,  // char
    64'h0000_0074_616F_6C66,  // float
    64'h0000_7463_7572_7473   // struct
  };
  localparam logic [3:0] KW_LEN [NUM_KW] = '{
    4'd3, 4'd3, 4'd2, 4'd4, 4'd5, 4'd6, 4'd4, 4'd5, 4'd6
  };

  // Input item
  typedef struct packed {
    logic [7:0] char_in;
    logic       end_mark;
  } csl_in_t;

  // Result item
  typedef struct packed {
    logic [2:0]  token_class;
    logic [15:0] token_index;
    logic [63:0] token_text;
    logic [3:0]  text_length;
    logic        truncated;
    logic        last_of_run;
  } csl_out_t;

  // One raw token: either a finished word still to be classified, or a single
  // operator / special token that is already final
  typedef struct packed {
    logic        is_word;
    logic [2:0]  cls;
    logic [63:0] text;
    logic [3:0]  len;
    logic        ovf;
  } csl_tok_t;

  // Queue entry: everything one input item causes
  typedef struct packed {
    logic     has0;
    csl_tok_t tok0;
    logic     has1;
    csl_tok_t tok1;
    logic     restart;   // numbering restarts after this entry
  } csl_entry_t;

  function automatic logic is_special(input logic [7:0] c);
    return c == CH_LPAREN || c == CH_RPAREN || c == CH_SEMI ||
           c == CH_LBRACE || c == CH_RBRACE || c == CH_QUOTE;
  endfunction

  function automatic logic is_operator(input logic [7:0] c);
    return c == CH_LT || c == CH_EQ || c == CH_PLUS || c == CH_STAR ||
           c == CH_MINUS || c == CH_SLASH || c == CH_PCT || c == CH_GT;
  endfunction

  // Text is zero beyond len, so a full-width compare is exact
  function automatic logic is_keyword(input logic [63:0] text, input logic [3:0] len);
    logic hit;
    hit = 1'b0;
    for (int k = 0; k < NUM_KW; k++) begin
      if (len == KW_LEN[k] && text == KW_TEXT[k]) hit = 1'b1;
    end
    return hit;
  endfunction

endpackage

[sv/csl_front.sv]
// Front end of the lexer: accepts characters, collects words, holds the plus
// lookahead and pushes raw tokens to the queue. Depends on csl_pkg.
module csl_front
  import csl_pkg::*;
#(
  parameter int MAX_WORD = 8
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  csl_in_t    item,
  output logic       push,
  output csl_entry_t entry
);

  localparam int LEN_W = $clog2(MAX_WORD + 1);
  localparam int IDX_W = $clog2(MAX_WORD);

  logic [7:0]       word_chars [MAX_WORD];
  logic [LEN_W-1:0] word_length, word_length_next;
  logic             word_overflow, word_overflow_next;
  logic             plus_pending, plus_pending_next;
  logic             store;

  logic [63:0] word_text;
  csl_tok_t    word_tok, plus_tok, pp_tok, single_tok;

  // Stored word, zero past the current length
  for (genvar i = 0; i < TEXT_BYTES; i++) begin : g_text
    if (i < MAX_WORD) begin : g_used
      assign word_text[8*i +: 8] = (LEN_W'(i) < word_length) ? word_chars[i] : 8'h00;
    end else begin : g_unused
      assign word_text[8*i +: 8] = 8'h00;
    end
  end

  always_comb begin
    word_tok   = '{is_word: 1'b1, cls: CLS_IDENT, text: word_text,
                   len: 4'(word_length), ovf: word_overflow};
    plus_tok   = '{is_word: 1'b0, cls: CLS_OPERATOR, text: {56'h0, CH_PLUS},
                   len: 4'd1, ovf: 1'b0};
    pp_tok     = '{is_word: 1'b0, cls: CLS_OPERATOR, text: {48'h0, CH_PLUS, CH_PLUS},
                   len: 4'd2, ovf: 1'b0};
    single_tok = '{is_word: 1'b0,
                   cls: is_special(item.char_in) ? CLS_SPECIAL : CLS_OPERATOR,
                   text: {56'h0, item.char_in}, len: 4'd1, ovf: 1'b0};
  end

  // Per-item decision: which tokens leave and how the word state moves
  always_comb begin
    logic done;
    done               = 1'b0;
    entry              = '0;
    store              = 1'b0;
    plus_pending_next  = plus_pending;
    word_length_next   = word_length;
    word_overflow_next = word_overflow;
    if (accept) begin
      if (item.end_mark) begin
        if (plus_pending) begin
          entry.has0 = 1'b1;
          entry.tok0 = plus_tok;
        end else if (word_length != '0) begin
          entry.has0 = 1'b1;
          entry.tok0 = word_tok;
        end
        entry.restart      = 1'b1;
        plus_pending_next  = 1'b0;
        word_length_next   = '0;
        word_overflow_next = 1'b0;
      end else begin
        // resolve the held plus first
        if (plus_pending) begin
          plus_pending_next = 1'b0;
          entry.has0        = 1'b1;
          if (item.char_in == CH_PLUS) begin
            entry.tok0 = pp_tok;
            done       = 1'b1;
          end else begin
            entry.tok0 = plus_tok;
          end
        end
        if (!done && item.char_in != CH_COMMA) begin
          if (item.char_in == CH_SPACE) begin
            if (word_length != '0) begin
              entry.has0         = 1'b1;
              entry.tok0         = word_tok;
              word_length_next   = '0;
              word_overflow_next = 1'b0;
            end
          end else if (is_special(item.char_in) || is_operator(item.char_in)) begin
            // a pending word implies no held plus, so it always takes slot 0
            if (word_length != '0) begin
              entry.has0         = 1'b1;
              entry.tok0         = word_tok;
              word_length_next   = '0;
              word_overflow_next = 1'b0;
            end
            if (item.char_in == CH_PLUS) begin
              plus_pending_next = 1'b1;
            end else if (entry.has0) begin
              entry.has1 = 1'b1;
              entry.tok1 = single_tok;
            end else begin
              entry.has0 = 1'b1;
              entry.tok0 = single_tok;
            end
          end else if (word_length < LEN_W'(MAX_WORD)) begin
            store            = 1'b1;
            word_length_next = word_length + 1'b1;
          end else begin
            word_overflow_next = 1'b1;
          end
        end
      end
    end
    push = entry.has0 || entry.restart;
  end

  // Word state
  always_ff @(posedge clk) begin
    if (rst) begin
      word_length   <= '0;
      word_overflow <= 1'b0;
      plus_pending  <= 1'b0;
    end else begin
      word_length   <= word_length_next;
      word_overflow <= word_overflow_next;
      plus_pending  <= plus_pending_next;
    end
  end

  // Character buffer, no reset
  always_ff @(posedge clk) begin
    if (store) word_chars[word_length[IDX_W-1:0]] <= item.char_in;
  end

endmodule

[sv/csl_queue.sv]
// Short FIFO of lexer entries between the front and back ends.
// Depends on csl_pkg.
module csl_queue
  import csl_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  csl_entry_t push_entry,
  input  logic       pop,
  output csl_entry_t head,
  output logic       full,
  output logic       empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  csl_entry_t       slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push, do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = slots[rd_ptr];

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (do_push && !do_pop)      count <= count + 1'b1;
      else if (do_pop && !do_push) count <= count - 1'b1;
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= push_entry;
  end

endmodule

[sv/csl_back.sv]
// Back end of the lexer: classifies words, numbers tokens and drives the
// registered result port. Depends on csl_pkg.
module csl_back
  import csl_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  csl_entry_t head,
  input  logic       head_valid,
  output logic       pop,
  output logic       token_valid,
  input  logic       token_stall,
  output csl_out_t   token_data
);

  logic        phase;          // 1: first token of head already sent
  logic [15:0] token_counter;
  logic        can_load, emit, last;
  csl_tok_t    cur;
  logic [63:0] digits;
  logic [3:0]  ndig;
  logic [7:0]  ch;
  logic        kw;
  csl_out_t    res;

  assign can_load = !token_valid || !token_stall;
  assign cur      = phase ? head.tok1 : head.tok0;
  assign emit     = head_valid && can_load && (phase || head.has0);
  assign pop      = head_valid && can_load && (phase || !head.has0 || !head.has1);
  assign last     = phase || !head.has1;

  // Digit extraction, left to right
  always_comb begin
    digits = '0;
    ndig   = '0;
    ch     = '0;
    for (int i = 0; i < TEXT_BYTES; i++) begin
      ch = cur.text[8*i +: 8];
      if (ch >= CH_ZERO && ch <= CH_NINE) begin
        digits[{ndig[2:0], 3'b000} +: 8] = ch;
        ndig = ndig + 1'b1;
      end
    end
  end

  // Word class: keyword, then number, then identifier
  always_comb begin
    kw                  = !cur.ovf && is_keyword(cur.text, cur.len);
    res.token_index     = token_counter;
    res.last_of_run     = last;
    res.token_class     = cur.cls;
    res.token_text      = cur.text;
    res.text_length     = cur.len;
    res.truncated       = 1'b0;
    if (cur.is_word) begin
      res.truncated = cur.ovf;
      if (kw) begin
        res.token_class = CLS_KEYWORD;
      end else if (ndig != '0) begin
        res.token_class = CLS_NUMBER;
        res.token_text  = digits;
        res.text_length = ndig;
      end else begin
        res.token_class = CLS_IDENT;
      end
    end
  end

  // Sequencing, numbering and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= 1'b0;
      token_counter <= 16'd1;
      token_valid   <= 1'b0;
    end else begin
      if (pop)       phase <= 1'b0;
      else if (emit) phase <= 1'b1;
      if (pop && head.restart) token_counter <= 16'd1;
      else if (emit)           token_counter <= (token_counter == 16'hFFFF) ? 16'd1
                                                : token_counter + 16'd1;
      if (can_load) token_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) token_data <= res;
  end

endmodule

[sv/char_stream_lexer_core.sv]
// Character stream lexer: one ASCII character per cycle in, classified tokens out.
// A front end collects words, a four-entry queue decouples it from the back end
// that classifies and numbers the tokens. A character is taken every cycle while
// the queue has room. Each token leaves in a cycle of its own, so a character
// that ends a word and is itself a token (or releases a held '+') gives the back
// end two tokens to send. Characters that cause no token cost the back end nothing,
// except an end mark with nothing pending, which still occupies the back end
// to restart the numbering. Sustained input rate is one character per cycle
// whenever the output does not stall and the stream averages at most one token or
// bare restart per character. Tokens are numbered from 1 and wrap to 1 after
// 65535; an end mark flushes any pending word or '+' and restarts the numbering.
// Words longer than MAX_WORD characters are cut and flagged truncated.
// Depends on csl_pkg, csl_front, csl_queue and csl_back.
module char_stream_lexer_core
  import csl_pkg::*;
#(
  parameter int MAX_WORD    = 8,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     char_valid,
  output logic     char_stall,
  input  csl_in_t  char_data,
  output logic     token_valid,
  input  logic     token_stall,
  output csl_out_t token_data
);

  logic       accept, push, pop, q_full, q_empty;
  csl_entry_t push_entry, head;

  assign char_stall = q_full;
  assign accept     = char_valid && !q_full;

  csl_front #(.MAX_WORD(MAX_WORD)) u_front (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .item   (char_data),
    .push   (push),
    .entry  (push_entry)
  );

  csl_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .full       (q_full),
    .empty      (q_empty)
  );

  csl_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .head_valid  (!q_empty),
    .pop         (pop),
    .token_valid (token_valid),
    .token_stall (token_stall),
    .token_data  (token_data)
  );

endmodule

[sv/csl_checker.sv]
// Port-level checks on the lexer's token output, bound to the top level.
// Depends on csl_pkg and char_stream_lexer_core.
module csl_checker
  import csl_pkg::*;
(
  input logic     clk,
  input logic     rst,
  input logic     token_valid,
  input logic     token_stall,
  input csl_out_t token_data
);

  // A stalled token holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    token_valid && token_stall |=> token_valid && $stable(token_data))
    else $error("stalled token changed");

  // Numbering never shows zero
  a_index: assert property (@(posedge clk) disable iff (rst)
    token_valid |-> token_data.token_index != 16'd0)
    else $error("token index zero");

  // Length within the text field, and never zero
  a_len: assert property (@(posedge clk) disable iff (rst)
    token_valid |-> token_data.text_length <= 4'd8 && token_data.text_length != 4'd0)
    else $error("bad text length");

  // Operator and special tokens are never truncated and have one or two characters
  a_single: assert property (@(posedge clk) disable iff (rst)
    token_valid && (token_data.token_class == CLS_OPERATOR ||
                    token_data.token_class == CLS_SPECIAL)
    |-> !token_data.truncated && token_data.text_length <= 4'd2)
    else $error("bad operator or special token");

endmodule

bind char_stream_lexer_core csl_checker u_csl_checker (
  .clk         (clk),
  .rst         (rst),
  .token_valid (token_valid),
  .token_stall (token_stall),
  .token_data  (token_data)
);
